// ===== hw/rtl/wsd_pkg.sv =====
// Shared types, constants and command codes of the wrist step detector.
package wsd_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY_COEFF  = 3'd0,
    CFG_EMA_COEFF      = 3'd1,
    CFG_THRESHOLD_GAIN = 3'd2,
    CFG_MIN_INTERVAL   = 3'd3,
    CFG_GYRO_GATE      = 3'd4
  } cfg_idx_e;

  // Register reset values
  localparam logic [15:0] GRAVITY_COEFF_RST  = 16'd1311;
  localparam logic [15:0] EMA_COEFF_RST      = 16'd655;
  localparam logic [15:0] THRESHOLD_GAIN_RST = 16'd4096;
  localparam logic [15:0] MIN_INTERVAL_RST   = 16'd220;
  localparam logic [15:0] GYRO_GATE_RST      = 16'd1968;

  // Q.8 acceleration limits (0.12 g, 0.08 g, 0.06 g, 0.05 g)
  localparam logic [19:0] K_012 = 20'd503316;
  localparam logic [19:0] K_008 = 20'd335544;
  localparam logic [19:0] K_006 = 20'd251658;
  localparam logic [19:0] K_005 = 20'd209715;

  // Q1.16 weights: 1.8, 1.5 and the 0.6 hysteresis
  localparam logic [16:0] W_MOT = 17'd117965;
  localparam logic [16:0] W_DEL = 17'd98304;
  localparam logic [16:0] HYST  = 17'd39322;

  // Datapath widths
  localparam int unsigned GRAV_W = 24;
  localparam int unsigned RAD_W  = 50;
  localparam int unsigned ROOT_W = 25;
  localparam int unsigned WALK_W = 27;
  localparam int unsigned THR_W  = 31;

  // Beat payloads
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic        [31:0] time_ms;
  } in_beat_t;

  typedef struct packed {
    logic step_found;
  } out_beat_t;

  // Work sequence of one sample
  typedef enum logic [4:0] {
    OP_GX,
    OP_GY,
    OP_LXX,
    OP_LYY,
    OP_ROOT_M,
    OP_DXX,
    OP_DYY,
    OP_ROOT_D,
    OP_GXX,
    OP_GYY,
    OP_GATE,
    OP_WM,
    OP_WD,
    OP_EMA,
    OP_THR,
    OP_LO,
    OP_FIN
  } op_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic wb_en;
    logic root_start;
    logic root_wb;
    logic finish;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/wsd_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface wsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wsd_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module wsd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wsd_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [wsd_pkg::ROOT_W-1:0]  root_o
);
  import wsd_pkg::*;

  logic [RAD_W-1:0] x_q, x_d, r_q, r_d, bit_q, bit_d, trial;
  logic             busy_q, busy_d, done_q, done_d;

  assign trial = r_q + bit_q;

  // Step one bit pair per cycle
  always_comb begin
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      x_d    = rad_i;
      r_d    = '0;
      bit_d  = RAD_W'(1) << (RAD_W - 2);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d = x_q - trial;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == RAD_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];
endmodule

// ===== hw/rtl/wsd_ctrl.sv =====
// Sequencer that walks the datapath through the work of one sample.
module wsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wsd_pkg::status_t status_i,
  output wsd_pkg::cmd_t    cmd_o
);
  import wsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WB   = 4'b0100,
    S_ROOT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  function automatic op_e next_op(op_e op);
    op_e n;
    case (op)
      OP_GX:     n = OP_GY;
      OP_GY:     n = OP_LXX;
      OP_LXX:    n = OP_LYY;
      OP_LYY:    n = OP_ROOT_M;
      OP_ROOT_M: n = OP_DXX;
      OP_DXX:    n = OP_DYY;
      OP_DYY:    n = OP_ROOT_D;
      OP_ROOT_D: n = OP_GXX;
      OP_GXX:    n = OP_GYY;
      OP_GYY:    n = OP_GATE;
      OP_GATE:   n = OP_WM;
      OP_WM:     n = OP_WD;
      OP_WD:     n = OP_EMA;
      OP_EMA:    n = OP_THR;
      OP_THR:    n = OP_LO;
      OP_LO:     n = OP_FIN;
      default:   n = OP_FIN;
    endcase
    return n;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);

  // Issue commands and advance the sequence
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = OP_GX;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        case (op_q) inside
          OP_ROOT_M, OP_ROOT_D: begin
            cmd_o.root_start = 1'b1;
            state_d          = S_ROOT;
          end
          OP_FIN: begin
            if (!status_i.out_busy) begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          end
          default: begin
            cmd_o.mul_en = 1'b1;
            state_d      = S_WB;
          end
        endcase
      end
      S_WB: begin
        cmd_o.wb_en = 1'b1;
        op_d        = next_op(op_q);
        state_d     = S_MUL;
      end
      S_ROOT: begin
        if (status_i.root_done) begin
          cmd_o.root_wb = 1'b1;
          op_d          = next_op(op_q);
          state_d       = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_GX;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end
endmodule

// ===== hw/rtl/wsd_datapath.sv =====
// Filter state, shared multiplier, square root and step decision.
module wsd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wsd_pkg::cmd_t                   cmd_i,
  output wsd_pkg::status_t                status_o,
  input  logic                            cfg_we_i,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wsd_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wsd_pkg::out_beat_t              out_data_o
);
  import wsd_pkg::*;

  // Configuration registers
  logic [15:0] grav_coef_q, ema_coef_q, gain_q, min_int_q, gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_coef_q <= GRAVITY_COEFF_RST;
      ema_coef_q  <= EMA_COEFF_RST;
      gain_q      <= THRESHOLD_GAIN_RST;
      min_int_q   <= MIN_INTERVAL_RST;
      gate_q      <= GYRO_GATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRAVITY_COEFF:  grav_coef_q <= cfg_data_i;
        CFG_EMA_COEFF:      ema_coef_q  <= cfg_data_i;
        CFG_THRESHOLD_GAIN: gain_q      <= cfg_data_i;
        CFG_MIN_INTERVAL:   min_int_q   <= cfg_data_i;
        CFG_GYRO_GATE:      gate_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample and working registers
  in_beat_t                 in_q;
  logic signed [57:0]       prod_q;
  logic [RAD_W-1:0]         acc_q;
  logic [ROOT_W-1:0]        motion_q, delta_q;
  logic [31:0]              gyro_sq_q, gate_sq_q;
  logic [WALK_W-1:0]        walk_q;
  logic [THR_W-1:0]         thr_q, lo_q;

  // Filter state
  logic signed [GRAV_W-1:0] grav_x_q, grav_y_q;
  logic signed [15:0]       prev_x_q, prev_y_q;
  logic [WALK_W-1:0]        avg_q, peak_q;
  logic                     above_q;
  logic [31:0]              last_q;

  // Result register
  logic                     out_valid_q;
  logic                     step_q;

  // Derived operands
  logic signed [23:0]       axq, ayq;
  logic signed [24:0]       lx, ly, dx, dy;
  logic signed [16:0]       dax, day;
  logic signed [27:0]       ema_diff;
  logic [27:0]              avg_bias;
  logic signed [31:0]       a_op;
  logic signed [25:0]       b_op;
  logic signed [57:0]       prod_sh16;
  logic [RAD_W-1:0]         acc_sum;
  logic [ROOT_W-1:0]        root;
  logic                     root_done;

  assign axq      = {in_q.accel_x, 8'h00};
  assign ayq      = {in_q.accel_y, 8'h00};
  assign lx       = 25'(axq) - 25'(grav_x_q);
  assign ly       = 25'(ayq) - 25'(grav_y_q);
  assign dax      = 17'(in_q.accel_x) - 17'(prev_x_q);
  assign day      = 17'(in_q.accel_y) - 17'(prev_y_q);
  assign dx       = {dax, 8'h00};
  assign dy       = {day, 8'h00};
  assign ema_diff = $signed({1'b0, walk_q}) - $signed({1'b0, avg_q});
  assign avg_bias = 28'(avg_q) + 28'(K_012);
  assign prod_sh16 = prod_q >>> 16;
  assign acc_sum  = acc_q + prod_q[RAD_W-1:0];

  // Select multiplier operands
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd_i.op)
      OP_GX:   begin a_op = 32'(lx);          b_op = {10'b0, grav_coef_q}; end
      OP_GY:   begin a_op = 32'(ly);          b_op = {10'b0, grav_coef_q}; end
      OP_LXX:  begin a_op = 32'(lx);          b_op = 26'(lx);              end
      OP_LYY:  begin a_op = 32'(ly);          b_op = 26'(ly);              end
      OP_DXX:  begin a_op = 32'(dx);          b_op = 26'(dx);              end
      OP_DYY:  begin a_op = 32'(dy);          b_op = 26'(dy);              end
      OP_GXX:  begin a_op = 32'(in_q.gyro_x); b_op = 26'(in_q.gyro_x);     end
      OP_GYY:  begin a_op = 32'(in_q.gyro_y); b_op = 26'(in_q.gyro_y);     end
      OP_GATE: begin a_op = {16'b0, gate_q};  b_op = {10'b0, gate_q};      end
      OP_WM:   begin a_op = {7'b0, motion_q}; b_op = {9'b0, W_MOT};        end
      OP_WD:   begin a_op = {7'b0, delta_q};  b_op = {9'b0, W_DEL};        end
      OP_EMA:  begin a_op = 32'(ema_diff);    b_op = {10'b0, ema_coef_q};  end
      OP_THR:  begin a_op = {4'b0, avg_bias}; b_op = {10'b0, gain_q};      end
      OP_LO:   begin a_op = {1'b0, thr_q};    b_op = {9'b0, HYST};         end
      default: begin a_op = '0;               b_op = '0;                   end
    endcase
  end

  // Shared square root
  wsd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.root_start),
    .rad_i  (acc_q),
    .done_o (root_done),
    .root_o (root)
  );

  // Step decision
  logic              start_cand, falling, elapsed_ok, step_ok;
  logic [WALK_W-1:0] peak_max;
  logic [31:0]       elapsed;

  assign start_cand = !above_q && ({4'b0, walk_q} > thr_q) && (gyro_sq_q < gate_sq_q) &&
                      (motion_q > ROOT_W'(K_008));
  assign peak_max   = (walk_q > peak_q) ? walk_q : peak_q;
  assign falling    = above_q && ({4'b0, walk_q} < lo_q);
  assign elapsed    = in_q.time_ms - last_q;
  assign elapsed_ok = elapsed >= {16'b0, min_int_q};
  assign step_ok    = falling && elapsed_ok &&
                      (33'(peak_max) > 33'(lo_q) + 33'(K_006)) &&
                      (motion_q > ROOT_W'(K_005)) && (delta_q > ROOT_W'(K_005));

  // Multiply, write back and hold working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= 58'(a_op) * 58'(b_op);
    end
    if (cmd_i.root_wb) begin
      if (cmd_i.op == OP_ROOT_M) begin
        motion_q <= root;
      end else begin
        delta_q <= root;
      end
    end
    if (cmd_i.wb_en) begin
      case (cmd_i.op) inside
        OP_LXX, OP_DXX, OP_GXX, OP_WM: acc_q <= prod_q[RAD_W-1:0];
        OP_LYY, OP_DYY:                acc_q <= acc_sum;
        OP_GYY:  gyro_sq_q <= acc_sum[31:0];
        OP_GATE: gate_sq_q <= prod_q[31:0];
        OP_WD:   walk_q    <= acc_sum[16 +: WALK_W];
        OP_THR:  thr_q     <= prod_q[12 +: THR_W];
        OP_LO:   lo_q      <= prod_q[16 +: THR_W];
        default: ;
      endcase
    end
  end

  // Filter state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q <= '0;
      grav_y_q <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      avg_q    <= '0;
      above_q  <= 1'b0;
      peak_q   <= '0;
      last_q   <= '0;
    end else begin
      if (cmd_i.wb_en) begin
        case (cmd_i.op)
          OP_GX:   grav_x_q <= grav_x_q + prod_sh16[GRAV_W-1:0];
          OP_GY:   grav_y_q <= grav_y_q + prod_sh16[GRAV_W-1:0];
          OP_EMA:  avg_q    <= avg_q + prod_sh16[WALK_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        prev_x_q <= in_q.accel_x;
        prev_y_q <= in_q.accel_y;
        if (start_cand) begin
          above_q <= 1'b1;
          peak_q  <= walk_q;
        end else if (above_q) begin
          if (falling) begin
            above_q <= 1'b0;
            peak_q  <= '0;
          end else begin
            peak_q <= peak_max;
          end
          if (step_ok) begin
            last_q <= in_q.time_ms;
          end
        end
      end
    end
  end

  // Result beat: set on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
      step_q      <= step_ok;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.step_found = step_q;
  assign status_o.root_done    = root_done;
  assign status_o.out_busy     = out_valid_q && !out_ready_i;
endmodule

// ===== hw/rtl/wrist_step_detector_unit.sv =====
// Wrist step detector top level: sequencer plus datapath.
//
// Each accepted sample beat (X/Y accel, X/Y gyro, millisecond time) yields
// exactly one result beat with step_found. The work between acceptance and
// a valid result beat is fourteen operations on one shared signed 32x26
// multiplier, each a multiply state then a write-back state, two runs of
// the iterative square root for the motion and delta magnitudes (start,
// one iteration per root bit, write back), and one finish step.
// The block works on one sample at a time; a new sample is accepted in the
// cycle after the previous one has been handed to the result register,
// even while that result still waits to be taken, so no sample goes in
// before the last one is done. The finish step holds while an older result
// beat still waits. The user writes registers through the plain write port
// only while no sample is in flight; the block itself does not enforce it.
module wrist_step_detector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wsd_stream_if.sink                     in_i,
  wsd_stream_if.source                   out_o
);
  import wsd_pkg::*;

  cmd_t    cmd;
  status_t status;

  wsd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wsd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_data_o (out_o.data)
  );
endmodule
